// ----- design/dfs_pkg.sv -----
// Shared constants for the depth-first path finder: field widths and operation codes.
`timescale 1ns / 1ps

package dfs_pkg;

  // Fixed field widths of the item and result ports
  localparam int VTX_W  = 5;   // vertex number on the item and result ports
  localparam int OP_W   = 2;   // operation code
  localparam int CNT_W  = 6;   // vertex_count register
  localparam int NEXT_W = 6;   // resume index kept with each stack entry
  localparam int FIELD_LIMIT = 32;  // vertices a 5-bit field can name

  // Operation codes; the fourth code is unused and dropped
  localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
  localparam logic [OP_W-1:0] OP_FIND  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

endpackage

// ----- design/dfs_path_finder.sv -----
// Depth-first path finder over an undirected adjacency matrix kept in RAM.
// An add item holds busy through S_ADD_WA, S_ADD_RB and S_ADD_WB; a clear item
// does not raise busy. A query does a row read (S_LOAD) and a neighbor pick
// (S_SCAN) per stack push, with a stack read (S_POP) added per backtrack; the
// path then leaves at one vertex per cycle. The single read port of the adjacency
// RAM sets the step time. Reset clears all edges at once through per-row valid
// bits and sets vertex_count to 32.
`timescale 1ns / 1ps

module dfs_path_finder #(
  parameter int MAX_VERTICES = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // item channel
  input  logic                     start,
  output logic                     busy,
  input  logic [dfs_pkg::OP_W-1:0] in_operation,
  input  logic [dfs_pkg::VTX_W-1:0] in_first_vertex,
  input  logic [dfs_pkg::VTX_W-1:0] in_second_vertex,
  // result channel
  output logic                     out_valid,
  output logic [dfs_pkg::VTX_W-1:0] out_path_vertex,
  output logic                     out_found,
  output logic                     out_last,
  // configuration port
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [2:0]               paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  // Vertices actually addressable: bounded by the parameter and the 5-bit fields
  localparam int NV = (MAX_VERTICES < dfs_pkg::FIELD_LIMIT) ? MAX_VERTICES
                                                             : dfs_pkg::FIELD_LIMIT;
  localparam int IW = $clog2(NV);          // vertex index / row / stack address
  localparam int DW = IW + 1;              // stack depth counter, holds NV
  localparam int SW = IW + dfs_pkg::NEXT_W; // stack entry: vertex, resume index

  typedef enum logic [9:0] {
    S_IDLE     = 10'b00_0000_0001,
    S_ADD_WA   = 10'b00_0000_0010,
    S_ADD_RB   = 10'b00_0000_0100,
    S_ADD_WB   = 10'b00_0000_1000,
    S_LOAD     = 10'b00_0001_0000,
    S_SCAN     = 10'b00_0010_0000,
    S_POP      = 10'b00_0100_0000,
    S_EMIT_TOP = 10'b00_1000_0000,
    S_EMIT     = 10'b01_0000_0000,
    S_SPARE    = 10'b10_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration
  logic [dfs_pkg::CNT_W-1:0] vcount_r, vcount_nxt;
  logic [dfs_pkg::CNT_W-1:0] n_w;
  logic                      cfg_wr;

  // Adjacency matrix: rows in RAM, a valid bit per row stands in for clearing
  logic [NV-1:0] row_valid_r, row_valid_nxt;
  logic          adj_we;
  logic [IW-1:0] adj_waddr, adj_raddr;
  logic [NV-1:0] adj_wdata, adj_rdata, adj_row;
  logic [IW-1:0] row_sel;

  // Search state; the top of the stack lives in registers
  logic [IW-1:0] edge_a_r, edge_a_nxt;
  logic [IW-1:0] edge_b_r, edge_b_nxt;
  logic [IW-1:0] top_v_r, top_v_nxt;
  logic [dfs_pkg::NEXT_W-1:0] top_next_r, top_next_nxt;
  logic [DW-1:0] depth_r, depth_nxt;
  logic [DW-1:0] emit_k_r, emit_k_nxt;
  logic [NV-1:0] visited_r, visited_nxt;

  // Stack RAM
  logic          stk_we;
  logic [IW-1:0] stk_waddr, stk_raddr;
  logic [SW-1:0] stk_wdata, stk_rdata;

  // Neighbor pick
  logic [NV-1:0] cand;
  logic          hit;
  logic [IW-1:0] pick;

  // Result register
  logic                     out_valid_r, out_valid_nxt;
  logic [dfs_pkg::VTX_W-1:0] out_vtx_r, out_vtx_nxt;
  logic                     out_found_r, out_found_nxt;
  logic                     out_last_r, out_last_nxt;

  logic accept;
  logic a_ok, b_ok;

  // Effective vertex count
  assign n_w = (vcount_r > dfs_pkg::CNT_W'(NV)) ? dfs_pkg::CNT_W'(NV) : vcount_r;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && !paddr[2];
  assign prdata = {{(32 - dfs_pkg::CNT_W){1'b0}}, vcount_r};
  assign vcount_nxt = cfg_wr ? pwdata[dfs_pkg::CNT_W-1:0] : vcount_r;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;
  assign a_ok   = {1'b0, in_first_vertex} < n_w;
  assign b_ok   = {1'b0, in_second_vertex} < n_w;

  // Mask off rows never written since the last clear
  always_comb begin
    unique case (state_r)
      S_ADD_WA: row_sel = edge_a_r;
      S_ADD_WB: row_sel = edge_b_r;
      default:  row_sel = top_v_r;
    endcase
  end
  assign adj_row = row_valid_r[row_sel] ? adj_rdata : '0;

  // Unvisited neighbors at or beyond the resume index, lowest first
  always_comb begin
    for (int j = 0; j < NV; j++) begin
      cand[j] = adj_row[j] && !visited_r[j]
                && (dfs_pkg::NEXT_W'(j) >= top_next_r)
                && (dfs_pkg::CNT_W'(j) < n_w)
                && (IW'(j) != top_v_r);
    end
  end

  always_comb begin
    pick = '0;
    for (int j = NV - 1; j >= 0; j--) begin
      if (cand[j]) begin
        pick = IW'(j);
      end
    end
  end
  assign hit = |cand;

  always_comb begin
    state_nxt     = state_r;
    row_valid_nxt = row_valid_r;
    edge_a_nxt    = edge_a_r;
    edge_b_nxt    = edge_b_r;
    top_v_nxt     = top_v_r;
    top_next_nxt  = top_next_r;
    depth_nxt     = depth_r;
    emit_k_nxt    = emit_k_r;
    visited_nxt   = visited_r;
    out_valid_nxt = 1'b0;
    out_vtx_nxt   = out_vtx_r;
    out_found_nxt = out_found_r;
    out_last_nxt  = out_last_r;
    adj_we        = 1'b0;
    adj_waddr     = edge_a_r;
    adj_wdata     = '0;
    adj_raddr     = top_v_r;
    stk_we        = 1'b0;
    stk_waddr     = '0;
    stk_wdata     = '0;
    stk_raddr     = '0;

    unique case (state_r)
      S_IDLE: begin
        adj_raddr = in_first_vertex[IW-1:0];
        if (accept) begin
          unique case (in_operation)
            dfs_pkg::OP_ADD: begin
              // drop edges that name a vertex out of range
              if (a_ok && b_ok) begin
                edge_a_nxt = in_first_vertex[IW-1:0];
                edge_b_nxt = in_second_vertex[IW-1:0];
                state_nxt  = S_ADD_WA;
              end
            end
            dfs_pkg::OP_FIND: begin
              if (a_ok && b_ok) begin
                visited_nxt  = NV'(1) << in_first_vertex[IW-1:0];
                top_v_nxt    = in_first_vertex[IW-1:0];
                edge_b_nxt   = in_second_vertex[IW-1:0];
                top_next_nxt = '0;
                depth_nxt    = DW'(1);
                state_nxt    = S_LOAD;
              end else begin
                out_valid_nxt = 1'b1;
                out_vtx_nxt   = '0;
                out_found_nxt = 1'b0;
                out_last_nxt  = 1'b1;
              end
            end
            dfs_pkg::OP_CLEAR: begin
              row_valid_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end

      S_ADD_WA: begin
        adj_we    = 1'b1;
        adj_waddr = edge_a_r;
        adj_wdata = adj_row | (NV'(1) << edge_b_r);
        row_valid_nxt[edge_a_r] = 1'b1;
        state_nxt = S_ADD_RB;
      end

      S_ADD_RB: begin
        adj_raddr = edge_b_r;
        state_nxt = S_ADD_WB;
      end

      S_ADD_WB: begin
        adj_we    = 1'b1;
        adj_waddr = edge_b_r;
        adj_wdata = adj_row | (NV'(1) << edge_a_r);
        row_valid_nxt[edge_b_r] = 1'b1;
        state_nxt = S_IDLE;
      end

      S_LOAD: begin
        // target on top: the stack holds the path
        adj_raddr = top_v_r;
        state_nxt = (top_v_r == edge_b_r) ? S_EMIT_TOP : S_SCAN;
      end

      S_SCAN: begin
        if (hit) begin
          // push: save the current top with its resume index
          stk_we       = 1'b1;
          stk_waddr    = IW'(depth_r - DW'(1));
          stk_wdata    = {top_v_r, dfs_pkg::NEXT_W'(pick) + dfs_pkg::NEXT_W'(1)};
          visited_nxt  = visited_r | (NV'(1) << pick);
          top_v_nxt    = pick;
          top_next_nxt = '0;
          depth_nxt    = depth_r + DW'(1);
          state_nxt    = S_LOAD;
        end else if (depth_r == DW'(1)) begin
          out_valid_nxt = 1'b1;
          out_vtx_nxt   = '0;
          out_found_nxt = 1'b0;
          out_last_nxt  = 1'b1;
          depth_nxt     = '0;
          state_nxt     = S_IDLE;
        end else begin
          stk_raddr = IW'(depth_r - DW'(2));
          depth_nxt = depth_r - DW'(1);
          state_nxt = S_POP;
        end
      end

      S_POP: begin
        top_v_nxt    = stk_rdata[SW-1 -: IW];
        top_next_nxt = stk_rdata[dfs_pkg::NEXT_W-1:0];
        state_nxt    = S_LOAD;
      end

      S_EMIT_TOP: begin
        out_valid_nxt = 1'b1;
        out_vtx_nxt   = dfs_pkg::VTX_W'(top_v_r);
        out_found_nxt = 1'b1;
        out_last_nxt  = (depth_r == DW'(1));
        if (depth_r == DW'(1)) begin
          state_nxt = S_IDLE;
        end else begin
          stk_raddr  = IW'(depth_r - DW'(2));
          emit_k_nxt = depth_r - DW'(2);
          state_nxt  = S_EMIT;
        end
      end

      S_EMIT: begin
        // walk the stack down toward the source, one entry a cycle
        out_valid_nxt = 1'b1;
        out_vtx_nxt   = dfs_pkg::VTX_W'(stk_rdata[SW-1 -: IW]);
        out_found_nxt = 1'b1;
        out_last_nxt  = (emit_k_r == '0);
        if (emit_k_r == '0) begin
          state_nxt = S_IDLE;
        end else begin
          stk_raddr  = IW'(emit_k_r - DW'(1));
          emit_k_nxt = emit_k_r - DW'(1);
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      vcount_r    <= dfs_pkg::CNT_W'(32);
      row_valid_r <= '0;
      depth_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      vcount_r    <= vcount_nxt;
      row_valid_r <= row_valid_nxt;
      depth_r     <= depth_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers: no reset
  always_ff @(posedge clk) begin
    edge_a_r    <= edge_a_nxt;
    edge_b_r    <= edge_b_nxt;
    top_v_r     <= top_v_nxt;
    top_next_r  <= top_next_nxt;
    emit_k_r    <= emit_k_nxt;
    visited_r   <= visited_nxt;
    out_vtx_r   <= out_vtx_nxt;
    out_found_r <= out_found_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_path_vertex = out_vtx_r;
  assign out_found       = out_found_r;
  assign out_last        = out_last_r;

  dfs_ram #(
    .WIDTH (NV),
    .DEPTH (NV)
  ) u_adj_ram (
    .clk   (clk),
    .we    (adj_we),
    .waddr (adj_waddr),
    .wdata (adj_wdata),
    .raddr (adj_raddr),
    .rdata (adj_rdata)
  );

  dfs_ram #(
    .WIDTH (SW),
    .DEPTH (NV)
  ) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  // The stack never grows past the vertex count
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= DW'(NV))
    else $error("stack depth beyond vertex count");

  // The vertex on top of the stack is always marked visited while scanning
  a_top_visited: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> visited_r[top_v_r])
    else $error("scanning from an unvisited vertex");

  // A not-found result is a single, final result carrying vertex zero
  a_not_found_form: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_found_r) |-> (out_last_r && (out_vtx_r == '0)))
    else $error("malformed not-found result");

  // A push from S_SCAN moves to S_LOAD with the stack one entry deeper
  a_push_then_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && hit) |=> (state_r == S_LOAD && depth_r == $past(depth_r) + DW'(1)))
    else $error("push did not advance the stack");

endmodule

// ----- design/dfs_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps

module dfs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule
